FILE: hdl/qds_pkg.sv
package qds_pkg;

   // coordinate and table sizing
   localparam int COORD_BITS = 12;
   localparam int TOL_BITS   = 12;
   localparam int KEPT_DEPTH = 64;
   localparam int IDX_BITS   = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(KEPT_DEPTH + 1);
   localparam int DIFF_BITS  = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;

   // reset value of the match tolerance
   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(35);

   // compare-exchange steps of the four-corner sorting network
   localparam int SORT_STEPS = 5;
   localparam int STEP_BITS  = $clog2(SORT_STEPS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SORT_STEPS - 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } corner_type;

   typedef corner_type [3:0] quad_type;

   // corner order: by x, then by y
   function automatic logic corner_less(corner_type a, corner_type b);
      logic res;
      if (a.x == b.x) begin
         res = (a.y < b.y);
      end else begin
         res = (a.x < b.x);
      end
      return res;
   endfunction

endpackage

FILE: hdl/qds_sort.sv
module qds_sort
   import qds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  quad_type corners,
   output quad_type sorted,
   output logic     done
);

   quad_type               c_ff, c_in;
   logic                   running_ff, running_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   corner_type             a_sel, b_sel, lo, hi;

   // pick the pair for this step
   always_comb begin
      case (step_ff)
         STEP_BITS'(0): begin a_sel = c_ff[0]; b_sel = c_ff[1]; end
         STEP_BITS'(1): begin a_sel = c_ff[2]; b_sel = c_ff[3]; end
         STEP_BITS'(2): begin a_sel = c_ff[0]; b_sel = c_ff[2]; end
         STEP_BITS'(3): begin a_sel = c_ff[1]; b_sel = c_ff[3]; end
         default:       begin a_sel = c_ff[1]; b_sel = c_ff[2]; end
      endcase
   end

   // shared compare-exchange unit
   always_comb begin
      if (corner_less(b_sel, a_sel)) begin
         lo = b_sel;
         hi = a_sel;
      end else begin
         lo = a_sel;
         hi = b_sel;
      end
   end

   // load new corners, or write the ordered pair back
   always_comb begin
      c_in       = c_ff;
      running_in = running_ff;
      step_in    = step_ff;
      if (load) begin
         c_in       = corners;
         running_in = 1'b1;
         step_in    = '0;
      end else if (running_ff) begin
         case (step_ff)
            STEP_BITS'(0): begin c_in[0] = lo; c_in[1] = hi; end
            STEP_BITS'(1): begin c_in[2] = lo; c_in[3] = hi; end
            STEP_BITS'(2): begin c_in[0] = lo; c_in[2] = hi; end
            STEP_BITS'(3): begin c_in[1] = lo; c_in[3] = hi; end
            default:       begin c_in[1] = lo; c_in[2] = hi; end
         endcase
         if (step_ff == STEP_LAST) begin
            running_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
      end
      c_ff <= c_in;
   end

   assign sorted = c_ff;
   assign done   = running_ff && (step_ff == STEP_LAST);

endmodule

FILE: hdl/qds_ref_table.sv
module qds_ref_table
   import qds_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  corner_type          wr_data,
   input  logic                rd_en,
   input  logic [IDX_BITS-1:0] rd_addr,
   output corner_type          rd_data
);

   corner_type ref_mem_ff [KEPT_DEPTH];
   corner_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ref_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ref_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/qds_match.sv
module qds_match
   import qds_pkg::*;
(
   input  corner_type          ref_corner,
   input  corner_type          entry,
   input  logic [TOL_BITS-1:0] tolerance,
   output logic                hit
);

   logic [DIFF_BITS-1:0] dx, dy, tol_ext;

   // per-axis distance against the tolerance
   always_comb begin
      tol_ext = DIFF_BITS'(tolerance);
      if (ref_corner.x > entry.x) begin
         dx = DIFF_BITS'(ref_corner.x - entry.x);
      end else begin
         dx = DIFF_BITS'(entry.x - ref_corner.x);
      end
      if (ref_corner.y > entry.y) begin
         dy = DIFF_BITS'(ref_corner.y - entry.y);
      end else begin
         dy = DIFF_BITS'(entry.y - ref_corner.y);
      end
      hit = (dx <= tol_ext) && (dy <= tol_ext);
   end

endmodule

FILE: hdl/quad_duplicate_suppressor.sv
// sequence: a taken request is sorted, each held reference is read and matched in turn,
//   then the registered result strobe rises; a full table holds 64 references
// throughput: one request at a time; busy falls as the strobe rises, so the next request
//   can be taken in the strobe cycle; the reference scan reads one table entry per cycle
// reset: synchronous, active high; empties the table and sets the tolerance to 35
// the receiver cannot stall: each result is shown for exactly one cycle
module quad_duplicate_suppressor
   import qds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_in_x0,
   input  logic [COORD_BITS-1:0] req_in_y0,
   input  logic [COORD_BITS-1:0] req_in_x1,
   input  logic [COORD_BITS-1:0] req_in_y1,
   input  logic [COORD_BITS-1:0] req_in_x2,
   input  logic [COORD_BITS-1:0] req_in_y2,
   input  logic [COORD_BITS-1:0] req_in_x3,
   input  logic [COORD_BITS-1:0] req_in_y3,
   input  logic                  req_set_end,
   input  logic                  csr_write_en,
   input  logic [TOL_BITS-1:0]   csr_write_data,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_out_x0,
   output logic [COORD_BITS-1:0] rsp_out_y0,
   output logic [COORD_BITS-1:0] rsp_out_x1,
   output logic [COORD_BITS-1:0] rsp_out_y1,
   output logic [COORD_BITS-1:0] rsp_out_x2,
   output logic [COORD_BITS-1:0] rsp_out_y2,
   output logic [COORD_BITS-1:0] rsp_out_x3,
   output logic [COORD_BITS-1:0] rsp_out_y3,
   output logic                  rsp_kept,
   output logic                  rsp_table_full,
   output logic                  rsp_out_set_end
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   scan_idx_ff;
   logic                  rd_pend_ff;
   logic                  dup_ff;
   logic                  set_end_ff;
   logic                  rsp_valid_ff;
   quad_type              out_quad_ff;
   logic                  kept_ff;
   logic                  full_ff;
   logic                  out_set_end_ff;

   logic                  accept;
   logic                  sort_done;
   quad_type              in_quad;
   quad_type              sorted;
   quad_type              snapped;
   corner_type            ref_corner;
   corner_type            rd_data;
   logic                  hit;
   logic                  issue;
   logic                  table_has_room;
   logic                  wr_en;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // corners as they arrive
   always_comb begin
      in_quad[0] = '{x: req_in_x0, y: req_in_y0};
      in_quad[1] = '{x: req_in_x1, y: req_in_y1};
      in_quad[2] = '{x: req_in_x2, y: req_in_y2};
      in_quad[3] = '{x: req_in_x3, y: req_in_y3};
   end

   qds_sort u_sort (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .corners (in_quad),
      .sorted  (sorted),
      .done    (sort_done)
   );

   // snap x of the inner corners and pick the reference corner
   always_comb begin
      snapped      = sorted;
      snapped[1].x = sorted[0].x;
      snapped[2].x = sorted[3].x;
      ref_corner.x = sorted[0].x;
      ref_corner.y = (sorted[0].y > sorted[1].y) ? sorted[1].y : sorted[0].y;
   end

   // table access
   assign issue          = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
   assign table_has_room = (count_ff < CNT_BITS'(KEPT_DEPTH));
   assign wr_en          = (state_ff == ST_FINISH) && !dup_ff && table_has_room;

   qds_ref_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (ref_corner),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   qds_match u_match (
      .ref_corner (ref_corner),
      .entry      (rd_data),
      .tolerance  (tol_ff),
      .hit        (hit)
   );

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  set_end_ff <= req_set_end;
                  state_ff   <= ST_SORT;
               end
            end
            ST_SORT: begin
               if (sort_done) begin
                  scan_idx_ff <= '0;
                  rd_pend_ff  <= 1'b0;
                  dup_ff      <= 1'b0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_pend_ff <= issue;
               if (issue) begin
                  scan_idx_ff <= scan_idx_ff + CNT_BITS'(1);
               end
               if (rd_pend_ff && hit) begin
                  dup_ff <= 1'b1;
               end
               if (!issue && !rd_pend_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               out_quad_ff    <= snapped;
               kept_ff        <= !dup_ff;
               full_ff        <= !dup_ff && !table_has_room;
               out_set_end_ff <= set_end_ff;
               rsp_valid_ff   <= 1'b1;
               if (set_end_ff) begin
                  count_ff <= '0;
               end else if (wr_en) begin
                  count_ff <= count_ff + CNT_BITS'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x0      = out_quad_ff[0].x;
   assign rsp_out_y0      = out_quad_ff[0].y;
   assign rsp_out_x1      = out_quad_ff[1].x;
   assign rsp_out_y1      = out_quad_ff[1].y;
   assign rsp_out_x2      = out_quad_ff[2].x;
   assign rsp_out_y2      = out_quad_ff[2].y;
   assign rsp_out_x3      = out_quad_ff[3].x;
   assign rsp_out_y3      = out_quad_ff[3].y;
   assign rsp_kept        = kept_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_out_set_end = out_set_end_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(KEPT_DEPTH))
      else $error("kept count beyond table depth");

   a_full_only_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && full_ff |-> kept_ff)
      else $error("table full flagged on a duplicate");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= count_ff))
      else $error("scan index ran past the kept count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid_ff)
      else $error("request taken but sequencer not busy");

endmodule
